// ===== design/rect_track_table_ttl_assert.svh =====
// ----------------------------------------------------------------------------
// rect_track_table_ttl assertion macros
// Clocked, reset-gated assertion wrappers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RECT_TRACK_TABLE_TTL_ASSERT_SVH
`define RECT_TRACK_TABLE_TTL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define RTT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RTT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`else

`define RTT_ASSERT(lbl, cond, msg)
`define RTT_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// ===== design/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants of the rectangle track table.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // table geometry
  localparam int MAX_TRACKS = 16;
  localparam int COORD_BITS = 12;
  localparam int IDX_W      = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int LIFE_W     = 8;
  localparam int LIMIT_W    = 12;
  localparam int RECT_W     = 4 * COORD_BITS;
  localparam int ENTRY_W    = RECT_W + LIFE_W;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 4;

  // register reset values
  localparam logic [LIMIT_W-1:0] OVERLAP_LIMIT_RST = LIMIT_W'(20);
  localparam logic [LIFE_W-1:0]  LIFE_TICKS_RST    = LIFE_W'(10);

  // command codes
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DUMP = 2'd2,
    CMD_NONE = 2'd3
  } rtt_op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_TICK_DONE = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5
  } rtt_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;   // latch the accepted beat, clear scan counters
    logic scan;    // walk the table
    logic finish;  // write the closing result
  } rtt_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;   // every entry read and consumed
    logic hit;         // add found a matching entry this cycle
    logic out_free;    // output register can take a result
    logic skip_final;  // dump of a non-empty table: last beat already loaded
  } rtt_sts_t;

endpackage

// ===== design/rtt_ram.sv =====
// ----------------------------------------------------------------------------
// rtt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtt_ctrl
// Command sequencer: accept a beat, walk the table, close with a result.
// ----------------------------------------------------------------------------
module rtt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       in_cmd,
  input  rtt_pkg::rtt_sts_t sts,
  output rtt_pkg::rtt_ctl_t ctl
);

  import rtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  state_t state, state_next;
  logic   start;

  // unused command code is taken and dropped
  assign s_tready = (state == S_IDLE);
  assign start    = s_tvalid && s_tready && (rtt_op_t'(in_cmd) != CMD_NONE);

  assign ctl.start  = start;
  assign ctl.scan   = (state == S_SCAN);
  assign ctl.finish = (state == S_FINAL);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        priority if (sts.hit) state_next = S_FINAL;
        else if (sts.scan_done) state_next = sts.skip_final ? S_IDLE : S_FINAL;
        else state_next = S_SCAN;
      end
      S_FINAL: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/rtt_datapath.sv =====
// ----------------------------------------------------------------------------
// rtt_datapath
// Scan counters, overlap compare, table count and the result register.
// ----------------------------------------------------------------------------
module rtt_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rtt_pkg::rtt_ctl_t                      ctl,
  output rtt_pkg::rtt_sts_t                      sts,
  input  logic [1:0]                             in_cmd,
  input  logic [rtt_pkg::COORD_BITS-1:0]         in_x,
  input  logic [rtt_pkg::COORD_BITS-1:0]         in_y,
  input  logic [rtt_pkg::COORD_BITS-1:0]         in_w,
  input  logic [rtt_pkg::COORD_BITS-1:0]         in_h,
  input  logic [rtt_pkg::LIMIT_W-1:0]            overlap_limit,
  input  logic [rtt_pkg::LIFE_W-1:0]             life_ticks,
  output logic                                   ram_re,
  output logic [rtt_pkg::IDX_W-1:0]              ram_raddr,
  input  logic [rtt_pkg::ENTRY_W-1:0]            ram_rdata,
  output logic                                   ram_we,
  output logic [rtt_pkg::IDX_W-1:0]              ram_waddr,
  output logic [rtt_pkg::ENTRY_W-1:0]            ram_wdata,
  output logic [rtt_pkg::CNT_W-1:0]              entry_count,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // slot[3:0], out_x[15:4], out_y[27:16], out_w[39:28], out_h[51:40],
  // live_count[56:52], zero pad[63:57]
  output logic [63:0]                            m_tdata,
  // status[2:0]
  output logic [rtt_pkg::STATUS_W-1:0]           m_tuser,
  output logic                                   m_tlast
);

  import rtt_pkg::*;

  localparam int CW = COORD_BITS;

  // overlap length of [a0, a0+al) and [b0, b0+bl), zero when none
  function automatic logic [CW:0] overlap_len(
    input logic [CW-1:0] a0,
    input logic [CW-1:0] al,
    input logic [CW-1:0] b0,
    input logic [CW-1:0] bl
  );
    logic [CW:0] lo;
    logic [CW:0] ae;
    logic [CW:0] be;
    logic [CW:0] hi;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, al};
    be = {1'b0, b0} + {1'b0, bl};
    hi = (ae < be) ? ae : be;
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

  // latched command
  rtt_op_t        op;
  logic [CW-1:0]  nx, ny, nw, nh;

  // scan state
  logic [CNT_W-1:0] rd_idx;
  logic [IDX_W-1:0] chk_idx;
  logic             rd_vld;
  logic [CNT_W-1:0] keep;
  logic [CNT_W-1:0] count;
  logic             hit;
  logic [IDX_W-1:0] hit_slot;

  // result register
  logic                out_valid;
  rtt_status_t         out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [CW-1:0]       ox, oy, ow_r, oh_r;
  logic [CNT_W-1:0]    out_live;
  logic                out_last;

  // combinational
  logic              out_free, go, issue, consume;
  logic [CW-1:0]     e_x, e_y, e_w, e_h;
  logic [LIFE_W-1:0] e_life;
  logic [CW:0]       ovl_w, ovl_h;
  logic              match, hit_now, keep_wr, dump_emit, fin, room, append;
  logic [RECT_W-1:0] new_rect;

  // stepping: a dump only moves when its beat has somewhere to go
  assign out_free = !out_valid || m_tready;
  assign go       = (op == CMD_DUMP) ? out_free : 1'b1;
  assign issue    = ctl.scan && go && (rd_idx < count);
  assign consume  = ctl.scan && go && rd_vld;

  assign ram_re    = issue;
  assign ram_raddr = rd_idx[IDX_W-1:0];

  // entry under test
  assign e_x    = ram_rdata[0*CW +: CW];
  assign e_y    = ram_rdata[1*CW +: CW];
  assign e_w    = ram_rdata[2*CW +: CW];
  assign e_h    = ram_rdata[3*CW +: CW];
  assign e_life = ram_rdata[RECT_W +: LIFE_W];

  // overlap test against the new rectangle
  assign ovl_w = overlap_len(e_x, e_w, nx, nw);
  assign ovl_h = overlap_len(e_y, e_h, ny, nh);
  assign match = (ovl_w != '0) && (ovl_w < {1'b0, overlap_limit}) &&
                 (ovl_h != '0) && (ovl_h < {1'b0, overlap_limit});

  assign hit_now   = consume && (op == CMD_ADD) && match;
  assign keep_wr   = consume && (op == CMD_TICK) && (e_life > LIFE_W'(1));
  assign dump_emit = consume && (op == CMD_DUMP);
  assign fin       = ctl.finish && out_free;
  assign room      = (count < CNT_W'(MAX_TRACKS));
  assign append    = fin && (op == CMD_ADD) && !hit && room;
  assign new_rect  = {nh, nw, ny, nx};

  // table write: refresh, compaction move, or append
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = {life_ticks, new_rect};
    priority if (hit_now) begin
      ram_we = 1'b1;
    end else if (keep_wr) begin
      ram_we    = 1'b1;
      ram_waddr = keep[IDX_W-1:0];
      ram_wdata = {e_life - LIFE_W'(1), ram_rdata[RECT_W-1:0]};
    end else if (append) begin
      ram_we    = 1'b1;
      ram_waddr = count[IDX_W-1:0];
    end else begin
      ram_we = 1'b0;
    end
  end

  // status to controller
  assign sts.scan_done  = !rd_vld && (rd_idx >= count);
  assign sts.hit        = hit_now;
  assign sts.out_free   = out_free;
  assign sts.skip_final = (op == CMD_DUMP) && (count != '0);

  assign entry_count = count;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.start) begin
        rd_vld <= 1'b0;
      end else if (ctl.scan && go) begin
        rd_vld <= issue;
      end
      if (append) begin
        count <= count + CNT_W'(1);
      end else if (fin && (op == CMD_TICK)) begin
        count <= keep;
      end
      if (dump_emit || fin) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command latch and scan counters
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op     <= rtt_op_t'(in_cmd);
      nx     <= in_x;
      ny     <= in_y;
      nw     <= in_w;
      nh     <= in_h;
      rd_idx <= '0;
      keep   <= '0;
      hit    <= 1'b0;
    end else begin
      if (issue) begin
        rd_idx  <= rd_idx + CNT_W'(1);
        chk_idx <= rd_idx[IDX_W-1:0];
      end
      if (hit_now) begin
        hit      <= 1'b1;
        hit_slot <= chk_idx;
      end
      if (keep_wr) begin
        keep <= keep + CNT_W'(1);
      end
    end
  end

  // result register load
  always_ff @(posedge clk) begin
    if (dump_emit) begin
      out_status <= ST_ENTRY;
      out_slot   <= SLOT_W'(chk_idx);
      ox         <= e_x;
      oy         <= e_y;
      ow_r       <= e_w;
      oh_r       <= e_h;
      out_live   <= count;
      out_last   <= (({1'b0, chk_idx} + CNT_W'(1)) == count);
    end else if (fin) begin
      ox       <= '0;
      oy       <= '0;
      ow_r     <= '0;
      oh_r     <= '0;
      out_last <= 1'b1;
      unique case (op)
        CMD_ADD: begin
          priority if (hit) begin
            out_status <= ST_UPDATED;
            out_slot   <= SLOT_W'(hit_slot);
            out_live   <= count;
          end else if (room) begin
            out_status <= ST_ADDED;
            out_slot   <= SLOT_W'(count[IDX_W-1:0]);
            out_live   <= count + CNT_W'(1);
          end else begin
            out_status <= ST_DROPPED;
            out_slot   <= '0;
            out_live   <= count;
          end
        end
        CMD_TICK: begin
          out_status <= ST_TICK_DONE;
          out_slot   <= '0;
          out_live   <= keep;
        end
        default: begin
          out_status <= ST_EMPTY;
          out_slot   <= '0;
          out_live   <= count;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'b0, out_live, oh_r, ow_r, oy, ox, out_slot};

endmodule

// ===== design/rect_track_table_ttl.sv =====
// ----------------------------------------------------------------------------
// rect_track_table_ttl
// Ordered table of up to 16 tracked rectangles with a time-to-live.
// ----------------------------------------------------------------------------
// The table sits in a single RAM with one read and one write port; every
// command walks the live entries through that read port at one entry per
// cycle while the walk is not stalled. An add stops its walk at the first
// matching entry; an add, a tick or an empty dump then closes with one
// result beat, and a dump of a non-empty table ends with the beat of its
// last entry. The closing beat of an add, a tick or an empty dump waits
// while the previous result is still unaccepted, and a dump walk stalls
// the same way while its beats back up on the master side. A result
// waiting in the output register does not hold off acceptance of the next
// command. Commands are handled one at a time. Command code 3 is accepted
// and ignored; the block stays ready. Registers: overlap_limit at byte
// address 0 (reset 20), life_ticks at byte address 4 (reset 10); write them
// only while no command is in flight.
// ----------------------------------------------------------------------------
`include "rect_track_table_ttl_assert.svh"

module rect_track_table_ttl (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // rect_x[11:0], rect_y[23:12], rect_w[35:24], rect_h[47:36]
  input  logic [47:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // slot[3:0], out_x[15:4], out_y[27:16], out_w[39:28], out_h[51:40],
  // live_count[56:52], zero pad[63:57]
  output logic [63:0] m_tdata,
  // status[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import rtt_pkg::*;

  localparam int CW = COORD_BITS;

  logic [LIMIT_W-1:0] overlap_limit;
  logic [LIFE_W-1:0]  life_ticks;
  logic               cfg_wr;

  rtt_ctl_t           ctl;
  rtt_sts_t           sts;

  logic               ram_re, ram_we;
  logic [IDX_W-1:0]   ram_raddr, ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
  logic [CNT_W-1:0]   entry_count;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_limit <= OVERLAP_LIMIT_RST;
      life_ticks    <= LIFE_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        life_ticks <= pwdata[LIFE_W-1:0];
      end else begin
        overlap_limit <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {{(32-LIFE_W){1'b0}}, life_ticks}
                           : {{(32-LIMIT_W){1'b0}}, overlap_limit};

  // sequencer
  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_cmd   (s_tuser),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath
  rtt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .in_cmd        (s_tuser),
    .in_x          (s_tdata[0 +: CW]),
    .in_y          (s_tdata[CW +: CW]),
    .in_w          (s_tdata[2*CW +: CW]),
    .in_h          (s_tdata[3*CW +: CW]),
    .overlap_limit (overlap_limit),
    .life_ticks    (life_ticks),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .entry_count   (entry_count),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

  // entry storage: life above rectangle
  rtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TRACKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // checks
  `RTT_ASSERT(a_count_bound, (entry_count <= CNT_W'(MAX_TRACKS)), "table count overflow")
  `RTT_ASSERT_IMPL(a_wr_in_table, ram_we, ({1'b0, ram_waddr} <= entry_count), "write past end")
  `RTT_ASSERT_IMPL(a_no_scan_idle, s_tready, (!ctl.scan && !ctl.finish), "busy while ready")

endmodule
